// ===== sv/http_chunked_body_decoder_top_assert.svh =====
// Assertion macros shared by the decoder files
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HCBD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hcbd assertion failed");
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT(lbl, clk, rst, prop)
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/hcbd_pkg.sv =====
package hcbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_DATA = 3'd1,
    PH_SKIP = 3'd2,
    PH_DONE = 3'd3,
    PH_ERR  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] SKIP_BYTES = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    kind_t      kind;
  } result_t;

endpackage

// ===== sv/hcbd_if.sv =====
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_body;

  modport source (output valid, output in_byte, output start_of_body, input ready);
  modport sink   (input valid, input in_byte, input start_of_body, output ready);
endinterface

interface hcbd_out_if;
  import hcbd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  kind_t      kind;

  modport source (output valid, output payload_byte, output kind, input ready);
  modport sink   (input valid, input payload_byte, input kind, output ready);
endinterface

// ===== sv/http_chunked_body_decoder_top.sv =====
// A result is presented in the cycle after the byte that causes it is accepted.
// Throughput: one byte per clock unless a held result waits; the parser output is combinational.
// The input stays ready while a held result is being taken in the same cycle.
// Reset: synchronous rst returns the parser to expect a size line and empties the output register.
`include "http_chunked_body_decoder_top_assert.svh"

module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  hcbd_in_if.sink  raw,
  hcbd_out_if.source payload
);
  import hcbd_pkg::*;

  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    in_ready;
  logic    step;

  assign in_ready  = !out_valid || payload.ready;
  assign raw.ready = in_ready;
  assign step      = raw.valid && in_ready;

  hcbd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (raw.in_byte),
    .start_of_body(raw.start_of_body),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (payload.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_res <= res;
    end
  end

  assign payload.valid        = out_valid;
  assign payload.payload_byte = out_res.payload_byte;
  assign payload.kind         = out_res.kind;

  `HCBD_ASSERT(a_result_lands, clk, rst, (step && res.valid) |=> out_valid)
  `HCBD_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> raw.ready)
  `HCBD_ASSERT(a_marker_zero, clk, rst, (out_valid && out_res.kind != KIND_DATA) |-> out_res.payload_byte == 8'd0)
  `HCBD_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid)

endmodule

// ===== sv/hcbd_parser.sv =====
`include "http_chunked_body_decoder_top_assert.svh"

module hcbd_parser #(
  parameter int SIZE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              start_of_body,
  output hcbd_pkg::result_t res
);
  import hcbd_pkg::*;

  localparam logic [SIZE_BITS-1:0] ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] size_value, size_value_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 digit_seen, digit_seen_next;
  logic                 digits_closed, digits_closed_next;
  logic                 cr_pending, cr_pending_next;
  logic [1:0]           skip_count, skip_count_next;

  phase_t               cur_phase;
  logic [SIZE_BITS-1:0] cur_size;
  logic [SIZE_BITS-1:0] cur_left;
  logic                 cur_seen;
  logic                 cur_closed;
  logic                 cur_cr;
  logic [1:0]           cur_skip;
  logic [1:0]           skip_dec;
  logic                 hex_ok;
  logic [3:0]           hex_val;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    cur_phase  = start_of_body ? PH_SIZE : phase;
    cur_size   = start_of_body ? '0 : size_value;
    cur_left   = start_of_body ? '0 : bytes_left;
    cur_seen   = start_of_body ? 1'b0 : digit_seen;
    cur_closed = start_of_body ? 1'b0 : digits_closed;
    cur_cr     = start_of_body ? 1'b0 : cr_pending;
    cur_skip   = start_of_body ? 2'd0 : skip_count;

    phase_next         = cur_phase;
    size_value_next    = cur_size;
    bytes_left_next    = cur_left;
    digit_seen_next    = cur_seen;
    digits_closed_next = cur_closed;
    cr_pending_next    = cur_cr;
    skip_count_next    = cur_skip;
    skip_dec           = (cur_skip != 2'd0) ? cur_skip - 2'd1 : 2'd0;

    res.valid        = 1'b0;
    res.payload_byte = 8'd0;
    res.kind         = KIND_DATA;

    unique case (cur_phase)
      PH_SIZE: begin
        if (cur_cr && in_byte == CHAR_LF) begin
          if (!cur_seen) begin
            phase_next = PH_ERR;
            res.valid  = 1'b1;
            res.kind   = KIND_ERR;
          end else if (cur_size == '0) begin
            phase_next = PH_DONE;
            res.valid  = 1'b1;
            res.kind   = KIND_END;
          end else begin
            bytes_left_next = cur_size;
            phase_next      = PH_DATA;
          end
        end else begin
          cr_pending_next = (in_byte == CHAR_CR);
          if (!cur_closed) begin
            if (hex_ok) begin
              if (cur_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                phase_next = PH_ERR;
                res.valid  = 1'b1;
                res.kind   = KIND_ERR;
              end else begin
                size_value_next = {cur_size[SIZE_BITS-5:0], hex_val};
                digit_seen_next = 1'b1;
              end
            end else if (!(in_byte == CHAR_SPACE && !cur_seen)) begin
              digits_closed_next = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        bytes_left_next  = cur_left - ONE;
        res.valid        = 1'b1;
        res.payload_byte = in_byte;
        res.kind         = KIND_DATA;
        if (cur_left == ONE) begin
          phase_next      = PH_SKIP;
          skip_count_next = SKIP_BYTES;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == 2'd0) begin
          phase_next         = PH_SIZE;
          size_value_next    = '0;
          digit_seen_next    = 1'b0;
          digits_closed_next = 1'b0;
          cr_pending_next    = 1'b0;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = PH_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      size_value    <= '0;
      bytes_left    <= '0;
      digit_seen    <= 1'b0;
      digits_closed <= 1'b0;
      cr_pending    <= 1'b0;
      skip_count    <= 2'd0;
    end else if (step) begin
      phase         <= phase_next;
      size_value    <= size_value_next;
      bytes_left    <= bytes_left_next;
      digit_seen    <= digit_seen_next;
      digits_closed <= digits_closed_next;
      cr_pending    <= cr_pending_next;
      skip_count    <= skip_count_next;
    end
  end

  `HCBD_ASSERT(a_data_left_nonzero, clk, rst, phase == PH_DATA |-> bytes_left != '0)
  `HCBD_ASSERT(a_skip_nonzero, clk, rst, phase == PH_SKIP |-> skip_count != 2'd0)
  `HCBD_ASSERT(a_idle_silent, clk, rst, (step && !start_of_body && (phase == PH_DONE || phase == PH_ERR)) |-> !res.valid)

endmodule

// ===== tb/sv/http_chunked_body_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module http_chunked_body_decoder_top_tb;
  import hcbd_pkg::*;

  localparam int SIZE_BITS = 32;
  localparam int RANDOM_BYTES = 650;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_X = 8'h78;

  typedef struct packed {
    logic [7:0] b;
    logic       sob;
    logic       typed;
    logic       has;
    logic [7:0] rb;
    kind_t      rk;
  } raw_row_t;

  logic clk;
  logic rst;
  bit   quiet_run;

  hcbd_in_if  raw_if ();
  hcbd_out_if pay_if ();

  http_chunked_body_decoder_top #(.SIZE_BITS(SIZE_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .raw(raw_if),
    .payload(pay_if)
  );

  phase_t               line_phase = PH_SIZE;
  logic [SIZE_BITS-1:0] size_acc   = '0;
  logic [SIZE_BITS-1:0] data_left  = '0;
  bit                   got_digit;
  bit                   digits_done;
  bit                   saw_cr;
  logic [1:0]           trail_left = '0;

  result_t  decoded_fifo [$];
  raw_row_t raw_body [$];
  raw_row_t row_cur;
  bit       body_start;

  int n_fail;
  int n_sent;
  int n_random;
  int n_payload;
  int n_end;
  int n_err;

  raw_row_t directed_rows [27] = '{
    '{8'h31,      1'b1, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_CR,    1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_LF,    1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{8'hFF,      1'b0, 1'b1, 1'b1, 8'hFF, KIND_DATA},
    '{8'h00,      1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{8'h00,      1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_SPACE, 1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_ZERO,  1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_LF,    1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_CR,    1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_LF,    1'b0, 1'b1, 1'b1, 8'h00, KIND_END},
    '{8'hFF,      1'b0, 1'b1, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_TAB,   1'b1, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_CR,    1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_X,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_CR,    1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_LF,    1'b0, 1'b1, 1'b1, 8'h00, KIND_ERR},
    '{CHAR_ZERO,  1'b1, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b0, 1'b0, 8'h00, KIND_DATA},
    '{CHAR_F,     1'b0, 1'b1, 1'b1, 8'h00, KIND_ERR}
  };

  function automatic void restart_line();
    line_phase  = PH_SIZE;
    size_acc    = '0;
    got_digit   = 1'b0;
    digits_done = 1'b0;
    saw_cr      = 1'b0;
  endfunction

  function automatic bit parse_raw_byte(input logic [7:0] b, input logic sob,
                                        output logic [7:0] pb, output kind_t k);
    logic [3:0] nib;
    bit         is_hex;
    pb = 8'h00;
    k  = KIND_DATA;
    nib = 4'h0;
    if (sob) begin
      restart_line();
      data_left  = '0;
      trail_left = '0;
    end
    case (line_phase)
      PH_SIZE: begin
        if (saw_cr && b == CHAR_LF) begin
          if (!got_digit) begin
            line_phase = PH_ERR;
            k = KIND_ERR;
            return 1'b1;
          end
          if (size_acc == '0) begin
            line_phase = PH_DONE;
            k = KIND_END;
            return 1'b1;
          end
          data_left  = size_acc;
          line_phase = PH_DATA;
          return 1'b0;
        end
        saw_cr = (b == CHAR_CR);
        if (digits_done) return 1'b0;
        is_hex = 1'b1;
        if (b >= 8'h30 && b <= 8'h39) nib = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) nib = 4'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) nib = 4'(b - 8'h37);
        else is_hex = 1'b0;
        if (is_hex) begin
          if (size_acc[SIZE_BITS-1 -: 4] != 4'h0) begin
            line_phase = PH_ERR;
            k = KIND_ERR;
            return 1'b1;
          end
          size_acc  = (size_acc << 4) | SIZE_BITS'(nib);
          got_digit = 1'b1;
        end else if (!(b == CHAR_SPACE && !got_digit)) begin
          digits_done = 1'b1;
        end
        return 1'b0;
      end
      PH_DATA: begin
        data_left = data_left - 1'b1;
        if (data_left == '0) begin
          line_phase = PH_SKIP;
          trail_left = SKIP_BYTES;
        end
        pb = b;
        return 1'b1;
      end
      PH_SKIP: begin
        if (trail_left > 2'd0) trail_left = trail_left - 2'd1;
        if (trail_left == 2'd0) restart_line();
        return 1'b0;
      end
      PH_DONE: begin
        return 1'b0;
      end
      default: begin
        line_phase = PH_ERR;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'(CHAR_ZERO + n);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + n - 4'd10);
  endfunction

  function automatic void put(input logic [7:0] b);
    raw_row_t row;
    row = '{b, body_start, 1'b0, 1'b0, 8'h00, KIND_DATA};
    raw_body.insert(raw_body.size(), row);
    body_start = 1'b0;
  endfunction

  function automatic void put_size_line(input logic [31:0] size);
    bit started;
    started = 1'b0;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) put(CHAR_SPACE);
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) put(CHAR_ZERO);
    for (int i = 7; i >= 0; i--) begin
      if (size[i*4 +: 4] != 4'h0 || i == 0) started = 1'b1;
      if (started) put(hex_char(size[i*4 +: 4]));
    end
    if ($urandom_range(3) == 0) begin
      put(CHAR_SEMI);
      repeat ($urandom_range(1, 5)) put(8'($urandom_range(8'h21, 8'h7E)));
    end
    if ($urandom_range(7) == 0) begin
      put(CHAR_CR);
      put(CHAR_X);
    end
    if ($urandom_range(9) == 0) put(CHAR_LF);
    put(CHAR_CR);
    put(CHAR_LF);
  endfunction

  function automatic void build_good_body();
    repeat ($urandom_range(0, 3)) begin
      logic [31:0] len;
      len = ($urandom_range(9) == 0) ? $urandom_range(21, 200) : $urandom_range(1, 20);
      put_size_line(len);
      repeat (len) put(8'($urandom));
      if ($urandom_range(3) == 0) begin
        put(8'($urandom));
        put(8'($urandom));
      end else begin
        put(CHAR_CR);
        put(CHAR_LF);
      end
    end
    put_size_line(32'd0);
    repeat ($urandom_range(0, 2)) put(8'($urandom));
  endfunction

  function automatic void build_broken_body();
    int cut;
    case ($urandom_range(4))
      0: begin
        repeat ($urandom_range(0, 3)) put($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
        put(CHAR_CR);
        put(CHAR_LF);
        repeat ($urandom_range(0, 3)) put(8'($urandom));
      end
      1: begin
        put(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 11)) put(hex_char(4'($urandom)));
        put(CHAR_CR);
        put(CHAR_LF);
        repeat ($urandom_range(0, 3)) put(8'($urandom));
      end
      2: begin
        build_good_body();
        cut = $urandom_range(raw_body.size() - 1);
        while (raw_body.size() > cut + 1) void'(raw_body.pop_back());
      end
      3: begin
        build_good_body();
        cut = $urandom_range(raw_body.size() - 1);
        raw_body[cut].b = 8'($urandom);
      end
      default: begin
        repeat ($urandom_range(4, 24)) begin
          if ($urandom_range(9) == 0) body_start = 1'b1;
          case ($urandom_range(5))
            0: put(hex_char(4'($urandom)));
            1: put(CHAR_SPACE);
            2: put(CHAR_CR);
            3: put(CHAR_LF);
            4: put(CHAR_TAB);
            default: put(8'($urandom));
          endcase
        end
      end
    endcase
  endfunction

  task automatic send_row(input raw_row_t r);
    while (!quiet_run && $urandom_range(99) < 33) begin
      raw_if.valid <= 1'b0;
      @(negedge clk);
    end
    raw_if.valid         <= 1'b1;
    raw_if.in_byte       <= r.b;
    raw_if.start_of_body <= r.sob;
    row_cur              <= r;
    do @(posedge clk); while (!raw_if.ready);
    n_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    result_t    want;
    result_t    fresh;
    logic [7:0] pb;
    kind_t      k;
    bit         has;
    if (rst) begin
      restart_line();
      data_left  = '0;
      trail_left = '0;
      decoded_fifo.delete();
    end else begin
      if (pay_if.valid && pay_if.ready) begin
        if (decoded_fifo.size() == 0) begin
          $display("%0t: expected no result, got byte %h kind %0d",
                   $time, pay_if.payload_byte, pay_if.kind);
          n_fail++;
        end else begin
          want = decoded_fifo.pop_front();
          if (want.payload_byte != pay_if.payload_byte) begin
            $display("%0t: payload_byte expected %h, got %h",
                     $time, want.payload_byte, pay_if.payload_byte);
            n_fail++;
          end
          if (want.kind != pay_if.kind) begin
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, pay_if.kind);
            n_fail++;
          end
          case (want.kind)
            KIND_DATA: n_payload++;
            KIND_END: n_end++;
            default: n_err++;
          endcase
        end
      end
      if (raw_if.valid && raw_if.ready) begin
        has = parse_raw_byte(raw_if.in_byte, raw_if.start_of_body, pb, k);
        if (row_cur.typed) begin
          has = row_cur.has;
          pb  = row_cur.rb;
          k   = row_cur.rk;
        end
        if (has) begin
          fresh = '{1'b1, pb, k};
          decoded_fifo.insert(decoded_fifo.size(), fresh);
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    pay_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      pay_if.ready <= quiet_run || $urandom_range(99) >= 33;
    end
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst                  = 1'b1;
    raw_if.valid         = 1'b0;
    raw_if.in_byte       = 8'h00;
    raw_if.start_of_body = 1'b0;
    row_cur              = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) send_row(directed_rows[i]);
    while (n_random < RANDOM_BYTES) begin
      raw_body.delete();
      body_start = 1'b1;
      if ($urandom_range(3) == 0) build_broken_body();
      else build_good_body();
      // hold both sides busy through the middle of the run
      quiet_run = (n_random >= 250 && n_random < 400);
      foreach (raw_body[i]) send_row(raw_body[i]);
      n_random += raw_body.size();
    end
    quiet_run = 1'b0;
    raw_if.valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Chunked decoder: %0d raw bytes accepted, %0d payload bytes checked,",
             n_sent, n_payload);
    $display("  %0d end-of-body and %0d size-line error markers checked, %0d mismatches",
             n_end, n_err, n_fail);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
